@@ rtl/core/iec_pkg.sv @@
// Package for the I/O extent coalescer: field widths and the structs that pass
// an access span and a flushed extent between modules. No dependencies.
package iec_pkg;

	localparam int OWNER_W   = 17;	// signed owner of an access
	localparam int OUT_OWN_W = 16;	// owner as reported in a flush
	localparam int START_W   = 48;	// offset and extent start
	localparam int COUNT_W   = 32;	// bytes per access
	localparam int CE_W      = 49;	// inclusive span end, bytes or blocks
	localparam int HLEN_W    = 50;	// held extent length
	localparam int OUT_LEN_W = 49;	// length as reported in a flush
	localparam int CALC_W    = 52;	// signed width for the extent compares

	typedef struct packed {
		logic                       op;
		logic signed [OWNER_W-1:0]  owner;
		logic        [START_W-1:0]  cs;
		logic        [CE_W-1:0]     ce;
	} span_t;

	typedef struct packed {
		logic [OUT_OWN_W-1:0] owner;
		logic [START_W-1:0]   start;
		logic [OUT_LEN_W-1:0] length;
	} flush_t;

endpackage

@@ rtl/core/iec_span.sv @@
// Turns one access (offset, count) into an inclusive span in bytes or blocks.
// Depends on iec_pkg.
module iec_span #(
	parameter int BLOCK_SHIFT = 12,
	parameter int OFFSET_BITS = 48
) (
	input  logic                         block_mode,
	input  logic                         op,
	input  logic signed [iec_pkg::OWNER_W-1:0] owner_id,
	input  logic [iec_pkg::START_W-1:0]  byte_offset,
	input  logic [iec_pkg::COUNT_W-1:0]  byte_count,
	output iec_pkg::span_t               span
);

	localparam int OFF_KEEP = (OFFSET_BITS < iec_pkg::START_W) ? OFFSET_BITS
	                                                           : iec_pkg::START_W;
	localparam logic [iec_pkg::START_W-1:0] OFF_MASK =
		{iec_pkg::START_W{1'b1}} >> (iec_pkg::START_W - OFF_KEEP);
	localparam logic [iec_pkg::CE_W-1:0] ROUND_UP =
		iec_pkg::CE_W'((64'd1 << BLOCK_SHIFT) - 64'd1);

	logic [iec_pkg::START_W-1:0] off;
	logic [iec_pkg::CE_W-1:0]    last;
	logic [iec_pkg::CE_W-1:0]    rounded;

	always_comb begin
		off     = byte_offset & OFF_MASK;
		last    = iec_pkg::CE_W'(off) + iec_pkg::CE_W'(byte_count) - iec_pkg::CE_W'(1);
		rounded = last + ROUND_UP;
		span.op    = op;
		span.owner = owner_id;
		if (block_mode) begin
			span.cs = off >> BLOCK_SHIFT;
			span.ce = rounded >> BLOCK_SHIFT;
		end else begin
			span.cs = off;
			span.ce = last;
		end
	end

endmodule

@@ rtl/core/iec_extent.sv @@
// Holds the running extent, decides merge, ignore or flush for one span and
// updates the extent on commit. Depends on iec_pkg.
module iec_extent (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           commit,
	input  iec_pkg::span_t span,
	output logic           emit,
	output iec_pkg::flush_t flush
);

	logic signed [iec_pkg::OWNER_W-1:0] owner_q;
	logic [iec_pkg::START_W-1:0]        start_q;
	logic [iec_pkg::HLEN_W-1:0]         len_q;

	logic signed [iec_pkg::CALC_W-1:0] cs, ce, ls, le, nxt, prv;
	logic restart, contained, grow_end, covers_all, grow_front;

	always_comb begin
		cs  = $signed(iec_pkg::CALC_W'(span.cs));
		ce  = $signed(iec_pkg::CALC_W'(span.ce));
		ls  = $signed(iec_pkg::CALC_W'(start_q));
		nxt = ls + $signed(iec_pkg::CALC_W'(len_q));
		le  = nxt - iec_pkg::CALC_W'(1);
		prv = ls - iec_pkg::CALC_W'(1);

		restart    = span.op || (cs > nxt) || (ce < prv);
		contained  = (cs >= ls) && (ce <= le);
		grow_end   = (cs >= ls) && (cs <= nxt) && (ce >= nxt);
		covers_all = (cs <= ls) && (ce >= le);
		grow_front = (cs < ls) && (ce >= prv) && (ce <= le);

		// only an owned, non-empty extent goes out on a restart
		emit         = restart && !owner_q[iec_pkg::OWNER_W-1] && (len_q != '0);
		flush.owner  = owner_q[iec_pkg::OUT_OWN_W-1:0];
		flush.start  = start_q;
		flush.length = len_q[iec_pkg::OUT_LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '1;
			start_q <= '0;
			len_q   <= '0;
		end else if (commit) begin
			if (restart) begin
				owner_q <= span.owner;
				start_q <= span.cs;
				len_q   <= iec_pkg::HLEN_W'(ce - cs + iec_pkg::CALC_W'(1));
			end else if (contained) begin
				// hold
			end else if (grow_end) begin
				len_q   <= iec_pkg::HLEN_W'(ce - ls + iec_pkg::CALC_W'(1));
			end else if (covers_all) begin
				start_q <= span.cs;
				len_q   <= iec_pkg::HLEN_W'(ce - cs + iec_pkg::CALC_W'(1));
			end else if (grow_front) begin
				start_q <= span.cs;
				len_q   <= iec_pkg::HLEN_W'(le - cs + iec_pkg::CALC_W'(1));
			end
		end
	end

endmodule

@@ rtl/core/io_extent_coalescer.sv @@
// Top level of the I/O extent coalescer: input register, extent tracker and
// flush output register. Depends on iec_pkg, iec_span and iec_extent.
//
// Coalesces a stream of file accesses (owner, byte offset, byte count) into one
// running extent and emits the held extent, if owned and not empty, whenever an access
// neither overlaps nor touches it or carries op 1. In block mode (cfg write of 1, the
// reset value) spans are kept in blocks of 2^BLOCK_SHIFT bytes with the end rounded up;
// in byte mode they are kept in bytes. The mode only affects accesses taken after the
// write, and must be changed only while the block is idle. Accesses with a negative
// owner or zero count are accepted and dropped. An accepted access is converted to a
// span before the input register and is resolved against the held extent from there;
// a flush it causes is loaded into the output register when the input register advances.
// One access is taken every cycle while in_ready is high; the extent compare-and-update
// loop has no register but the extent's own. in_ready drops only when a flush waits in
// the output register, is not being taken, and the access in the input register would
// produce another one.
module io_extent_coalescer #(
	parameter int BLOCK_SHIFT = 12,
	parameter int OFFSET_BITS = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data,
	// access items
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic signed [iec_pkg::OWNER_W-1:0]   owner_id,
	input  logic [iec_pkg::START_W-1:0]          byte_offset,
	input  logic [iec_pkg::COUNT_W-1:0]          byte_count,
	// flushed extents
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [iec_pkg::OUT_OWN_W-1:0]        flushed_owner,
	output logic [iec_pkg::START_W-1:0]          flushed_start,
	output logic [iec_pkg::OUT_LEN_W-1:0]        flushed_length
);

	logic            block_mode_q;
	iec_pkg::span_t  span;
	iec_pkg::span_t  span_s1;
	logic            valid_s1;
	logic            adv_s1;
	logic            emit;
	iec_pkg::flush_t flush;
	iec_pkg::flush_t flush_q;
	logic            out_valid_q;
	logic            in_take;
	logic            keep;

	// mode register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_mode_q <= 1'b1;
		end else if (cfg_valid) begin
			block_mode_q <= cfg_data;
		end
	end

	// convert the access to a span ahead of the input register
	iec_span #(
		.BLOCK_SHIFT(BLOCK_SHIFT),
		.OFFSET_BITS(OFFSET_BITS)
	) u_span (
		.block_mode (block_mode_q),
		.op         (op),
		.owner_id   (owner_id),
		.byte_offset(byte_offset),
		.byte_count (byte_count),
		.span       (span)
	);

	// advance the input register unless a second flush would collide
	assign adv_s1   = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_take  = in_valid && in_ready;
	// drop accesses with a negative owner or no bytes
	assign keep     = !owner_id[iec_pkg::OWNER_W-1] && (byte_count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_take && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			span_s1 <= span;
		end
	end

	iec_extent u_extent (
		.clk   (clk),
		.arst_n(arst_n),
		.commit(adv_s1),
		.span  (span_s1),
		.emit  (emit),
		.flush (flush)
	);

	// output register: load a flush, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			flush_q <= flush;
		end
	end

	assign out_valid      = out_valid_q;
	assign flushed_owner  = flush_q.owner;
	assign flushed_start  = flush_q.start;
	assign flushed_length = flush_q.length;

endmodule

@@ verif/iec_flush_checker.sv @@
// Flush checker for io_extent_coalescer: follows the mode register and the access
// stream, predicts each flushed extent and compares it field by field on output.
// Depends on iec_pkg.
module iec_flush_checker #(
	parameter int BLOCK_SHIFT = 12,
	parameter int OFFSET_BITS = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic                                cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                op,
	input  logic signed [iec_pkg::OWNER_W-1:0]  owner_id,
	input  logic [iec_pkg::START_W-1:0]         byte_offset,
	input  logic [iec_pkg::COUNT_W-1:0]         byte_count,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [iec_pkg::OUT_OWN_W-1:0]       flushed_owner,
	input  logic [iec_pkg::START_W-1:0]         flushed_start,
	input  logic [iec_pkg::OUT_LEN_W-1:0]       flushed_length,
	output int                                  flush_errors,
	output int                                  flushes_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic                               mode_blocks;
	logic signed [iec_pkg::OWNER_W-1:0] ext_owner;
	longint                             ext_start;
	longint                             ext_length;
	iec_pkg::flush_t                    flushes_due[$];
	int                                 err_count = 0;

	assign flush_errors = err_count;

	// Fold one access into the running extent; return 1 with the flushed extent
	// when the access pushes a reportable extent out.
	function automatic bit track_access(input logic acc_op,
			input logic signed [iec_pkg::OWNER_W-1:0] acc_owner,
			input logic [iec_pkg::START_W-1:0] acc_off,
			input logic [iec_pkg::COUNT_W-1:0] acc_cnt, output iec_pkg::flush_t flushed);
		longint unsigned off_v;
		longint unsigned last_byte;
		longint          span_lo;
		longint          span_hi;
		longint          ext_hi;
		bit              emit;
		flushed = '0;
		if (acc_owner < 0 || acc_cnt == 0)
			return 1'b0;
		off_v = acc_off & ((64'd1 << OFFSET_BITS) - 64'd1);
		last_byte = off_v + acc_cnt - 64'd1;
		if (mode_blocks) begin
			span_lo = off_v >> BLOCK_SHIFT;
			span_hi = (last_byte + ((64'd1 << BLOCK_SHIFT) - 64'd1)) >> BLOCK_SHIFT;
		end else begin
			span_lo = off_v;
			span_hi = last_byte;
		end
		ext_hi = ext_start + ext_length - 1;
		if (acc_op || span_lo > ext_hi + 1 || span_hi < ext_start - 1) begin
			emit = (ext_owner >= 0 && ext_length != 0);
			if (emit) begin
				flushed.owner  = iec_pkg::OUT_OWN_W'(ext_owner);
				flushed.start  = iec_pkg::START_W'(ext_start);
				flushed.length = iec_pkg::OUT_LEN_W'(ext_length);
			end
			ext_owner  = acc_owner;
			ext_start  = span_lo;
			ext_length = span_hi - span_lo + 1;
			return emit;
		end
		if (span_lo >= ext_start && span_hi <= ext_hi)
			return 1'b0;
		if (span_lo >= ext_start && span_lo <= ext_hi + 1 && span_hi >= ext_hi + 1) begin
			ext_length += span_hi - ext_hi;
		end else if (span_lo <= ext_start && span_hi >= ext_hi) begin
			ext_start  = span_lo;
			ext_length = span_hi - span_lo + 1;
		end else if (span_lo < ext_start && span_hi >= ext_start - 1 && span_hi <= ext_hi) begin
			ext_length += ext_start - span_lo;
			ext_start  = span_lo;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		iec_pkg::flush_t want;
		iec_pkg::flush_t due;
		if (!arst_n) begin
			mode_blocks = 1'b1;
			ext_owner   = '1;
			ext_start   = 0;
			ext_length  = 0;
			flushes_due.delete();
			flushes_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_blocks = cfg_data;
			// results leave only after the access that causes them is taken, so retire before predicting
			if (out_valid && out_ready) begin
				if (flushes_due.size() == 0) begin
					$display("%0t unexpected flush: expected none, actual owner %h start %h length %h",
						$time, flushed_owner, flushed_start, flushed_length);
					err_count++;
				end else begin
					want = flushes_due.pop_front();
					if (flushed_owner !== want.owner) begin
						$display("%0t flushed_owner: expected %h, actual %h",
							$time, want.owner, flushed_owner);
						err_count++;
					end
					if (flushed_start !== want.start) begin
						$display("%0t flushed_start: expected %h, actual %h",
							$time, want.start, flushed_start);
						err_count++;
					end
					if (flushed_length !== want.length) begin
						$display("%0t flushed_length: expected %h, actual %h",
							$time, want.length, flushed_length);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (track_access(op, owner_id, byte_offset, byte_count, due))
					flushes_due.push_back(due);
			end
			flushes_owed <= flushes_due.size();
		end
	end

endmodule

@@ verif/tb_io_extent_coalescer.sv @@
// Testbench top for io_extent_coalescer: clock, reset, access stimulus, output
// back-pressure, watchdog and verdict. Depends on iec_pkg and iec_flush_checker.
module tb_io_extent_coalescer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_SHIFT = 12;
	localparam int OFFSET_BITS = 48;
	// cycles with no item moving on any channel before the run is called hung
	localparam int STUCK_LIMIT = 1000;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic                               cfg_data = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic                               op = 1'b0;
	logic signed [iec_pkg::OWNER_W-1:0] owner_id = '0;
	logic [iec_pkg::START_W-1:0]        byte_offset = '0;
	logic [iec_pkg::COUNT_W-1:0]        byte_count = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [iec_pkg::OUT_OWN_W-1:0]      flushed_owner;
	logic [iec_pkg::START_W-1:0]        flushed_start;
	logic [iec_pkg::OUT_LEN_W-1:0]      flushed_length;
	int                                 flush_errors;
	int                                 flushes_owed;

	// idle rates in percent per cycle
	int                                 tx_idle_pct = 11;
	int                                 rx_idle_pct = 49;
	int                                 stuck_cycles = 0;

	// shape of the last valid access, used to aim the next one at the held extent
	logic                               blocks_now = 1'b1;
	logic [iec_pkg::START_W-1:0]        recent_off = '0;
	logic [iec_pkg::START_W-1:0]        recent_end = '0;
	logic signed [iec_pkg::OWNER_W-1:0] recent_owner = 17'sd1;

	io_extent_coalescer #(
		.BLOCK_SHIFT(BLOCK_SHIFT),
		.OFFSET_BITS(OFFSET_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.owner_id      (owner_id),
		.byte_offset   (byte_offset),
		.byte_count    (byte_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.flushed_owner (flushed_owner),
		.flushed_start (flushed_start),
		.flushed_length(flushed_length)
	);

	iec_flush_checker #(
		.BLOCK_SHIFT(BLOCK_SHIFT),
		.OFFSET_BITS(OFFSET_BITS)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.owner_id      (owner_id),
		.byte_offset   (byte_offset),
		.byte_count    (byte_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.flushed_owner (flushed_owner),
		.flushed_start (flushed_start),
		.flushed_length(flushed_length),
		.flush_errors  (flush_errors),
		.flushes_owed  (flushes_owed)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver: drop ready at the current rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog: any item moving on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Present one access and hold it until it is taken. Valid stays high on
	// return so that the next item can follow without a bubble; a gap, when one
	// is drawn, lowers valid first.
	task automatic send_access(input logic acc_op,
			input logic signed [iec_pkg::OWNER_W-1:0] acc_owner,
			input logic [iec_pkg::START_W-1:0] acc_off,
			input logic [iec_pkg::COUNT_W-1:0] acc_cnt);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid    <= 1'b1;
		op          <= acc_op;
		owner_id    <= acc_owner;
		byte_offset <= acc_off;
		byte_count  <= acc_cnt;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending, let every owed flush drain, then allow for the two-stage
	// pipe, since the last access may still be in flight without owing a flush.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (flushes_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	// Change the unit of new spans; only ever done with the block idle.
	task automatic write_mode(input logic blocks);
		settle();
		cfg_valid  <= 1'b1;
		cfg_data   <= blocks;
		blocks_now = blocks;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly accesses aimed at the held extent (touching, overlapping, contained,
	// just clear of it), plus restarts, wholly random accesses and ignored ones.
	task automatic random_accesses(input int n);
		logic                               acc_op;
		logic signed [iec_pkg::OWNER_W-1:0] acc_owner;
		logic [iec_pkg::START_W-1:0]        acc_off;
		logic [iec_pkg::COUNT_W-1:0]        acc_cnt;
		int                                 pick;
		int                                 reach;
		repeat (n) begin
			pick      = $urandom_range(99);
			reach     = blocks_now ? 20000 : 6;
			acc_op    = 1'b0;
			acc_owner = recent_owner;
			acc_off   = recent_off;
			acc_cnt   = blocks_now ? $urandom_range(1, 20000) : $urandom_range(1, 300);
			if ($urandom_range(9) == 0)
				acc_owner = 17'($urandom_range(0, 65535));
			if (pick < 5) begin
				// ignored: no owner, or nothing accessed
				acc_op = 1'($urandom_range(1));
				if ($urandom_range(1))
					acc_owner = -17'sd1;
				else
					acc_cnt = '0;
			end else if (pick < 20) begin
				acc_op    = 1'($urandom_range(1));
				acc_owner = 17'($urandom_range(0, 65535));
				acc_off   = 48'({$urandom, $urandom});
				acc_cnt   = $urandom;
			end else if (pick < 30) begin
				acc_op  = 1'b1;
				acc_off = recent_end + $urandom_range(0, reach);
			end else begin
				case ($urandom_range(5))
					0: acc_off = recent_end + 1;
					1: acc_off = recent_off + $urandom_range(0, 300);
					2: acc_off = recent_off - acc_cnt;
					3: acc_off = recent_end + 1 + $urandom_range(1, reach);
					4: acc_off = recent_off - acc_cnt - $urandom_range(1, reach);
					default: begin
						acc_off = recent_off + $urandom_range(0, 4);
						acc_cnt = $urandom_range(1, 8);
					end
				endcase
			end
			send_access(acc_op, acc_owner, acc_off, acc_cnt);
			if (acc_owner >= 0 && acc_cnt != 0) begin
				recent_owner = acc_owner;
				recent_off   = acc_off;
				recent_end   = acc_off + acc_cnt - 1;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Block mode, the reset setting. Grow the ownerless extent left by reset;
		// it must never be reported.
		send_access(1'b0, 17'sd3, 48'h0, 32'd1);
		send_access(1'b0, 17'sd3, 48'h1000, 32'h1000);
		// restart flushes the ownerless extent silently, then blocks 16..18
		send_access(1'b1, 17'sd7, 48'h10000, 32'h2000);
		// contained, grow at the end, grow at the front, cover the whole: owner stays 7
		send_access(1'b0, 17'sd9, 48'h11000, 32'd1);
		send_access(1'b0, 17'sd9, 48'h13000, 32'h1000);
		send_access(1'b0, 17'sd9, 48'hF000, 32'h800);
		send_access(1'b0, 17'sd9, 48'hD000, 32'hA000);
		// disjoint: flush owner 7
		send_access(1'b0, 17'sd9, 48'h40000, 32'd1);
		// ignored: no owner, then an empty count
		send_access(1'b1, -17'sd1, 48'h0, 32'd5);
		send_access(1'b1, 17'sd4, 48'h50000, 32'd0);
		// field extremes, with the end rounded up past the top of the offset range
		send_access(1'b1, 17'sd65535, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_access(1'b1, 17'sd0, 48'h0, 32'hFFFF_FFFF);

		// Byte mode with a block-sized extent still held: it keeps its units.
		write_mode(1'b0);
		send_access(1'b0, 17'sd0, 48'h0, 32'd1);
		send_access(1'b1, 17'sd2, 48'd100, 32'd10);
		send_access(1'b0, 17'sd2, 48'd110, 32'd5);
		send_access(1'b0, 17'sd2, 48'd90, 32'd10);
		send_access(1'b0, 17'sd2, 48'd80, 32'd50);
		// one byte clear either side is disjoint
		send_access(1'b0, 17'sd2, 48'd131, 32'd1);
		send_access(1'b0, 17'sd5, 48'd129, 32'd1);
		send_access(1'b1, 17'sd1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_access(1'b1, 17'sd1, 48'h0, 32'd1);

		random_accesses(640);

		// swap the idle rates: a slow sender, an eager receiver
		write_mode(1'b1);
		tx_idle_pct = 49;
		rx_idle_pct <= 11;
		random_accesses(640);

		// no idling at all, through both modes
		write_mode(1'b0);
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		random_accesses(320);
		write_mode(1'b1);
		random_accesses(320);

		// drain, then give the pipe time to show any stray flush
		in_valid <= 1'b0;
		do @(posedge clk); while (flushes_owed != 0);
		repeat (8) @(posedge clk);
		if (flush_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
